### src/axis_angle_point_rotator_unit_assert.svh
`ifndef AXIS_ANGLE_POINT_ROTATOR_UNIT_ASSERT_SVH
`define AXIS_ANGLE_POINT_ROTATOR_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define AAPR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("axis_angle_point_rotator_unit: assertion failed");

// next-cycle implication, off during reset
`define AAPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("axis_angle_point_rotator_unit: assertion failed");

// next-cycle implication, active during reset
`define AAPR_ASSERT_NEXT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("axis_angle_point_rotator_unit: assertion failed");

`endif

### src/aapr_pkg.sv
package aapr_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANG_W = 17;
    localparam int RED_W = 18;
    localparam int X_W = 34;
    localparam int Z_W = 26;
    localparam int E_W = 32;
    localparam int ANGLE_FULL = 46080;
    localparam int ANGLE_HALF = 23040;
    localparam int ANGLE_QUARTER = 11520;
    localparam int GAIN_Q30 = 652032874;
    localparam int ONE_Q30 = 1073741824;

    typedef logic signed [E_W-1:0] t_ent;
    typedef t_ent [8:0] t_mat;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
    } t_point;

    typedef struct packed {
        t_point             pt;
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic signed [15:0] uz;
    } t_side;

    // atan(2^-i) in degrees, Q16
    function automatic logic signed [Z_W-1:0] atan_q16(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = Z_W'(2949120);
            1:       v = Z_W'(1740967);
            2:       v = Z_W'(919879);
            3:       v = Z_W'(466945);
            4:       v = Z_W'(234379);
            5:       v = Z_W'(117304);
            6:       v = Z_W'(58666);
            7:       v = Z_W'(29335);
            8:       v = Z_W'(14668);
            9:       v = Z_W'(7334);
            10:      v = Z_W'(3667);
            11:      v = Z_W'(1833);
            12:      v = Z_W'(917);
            13:      v = Z_W'(458);
            14:      v = Z_W'(229);
            15:      v = Z_W'(115);
            16:      v = Z_W'(57);
            17:      v = Z_W'(29);
            18:      v = Z_W'(14);
            19:      v = Z_W'(7);
            20:      v = Z_W'(4);
            21:      v = Z_W'(2);
            22:      v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### src/aapr_angle_fold.sv
module aapr_angle_fold (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [aapr_pkg::ANG_W-1:0]   i_angle,
    input  aapr_pkg::t_side                     i_side,
    output logic                                o_valid,
    output logic signed [aapr_pkg::Z_W-1:0]     o_z,
    output logic                                o_neg,
    output aapr_pkg::t_side                     o_side
);

    localparam int RW = aapr_pkg::RED_W;
    localparam logic signed [RW-1:0] FULL = RW'(aapr_pkg::ANGLE_FULL);
    localparam logic signed [RW-1:0] FULL2 = RW'(2 * aapr_pkg::ANGLE_FULL);
    localparam logic signed [RW-1:0] HALF = RW'(aapr_pkg::ANGLE_HALF);
    localparam logic signed [RW-1:0] QUART = RW'(aapr_pkg::ANGLE_QUARTER);

    logic signed [RW-1:0]          a;
    logic signed [RW-1:0]          r;
    logic signed [RW-1:0]          f;
    logic                          n_neg;
    logic signed [aapr_pkg::Z_W-1:0] n_z;
    logic                          r_valid;
    logic signed [aapr_pkg::Z_W-1:0] r_z;
    logic                          r_neg;
    aapr_pkg::t_side               r_side;

    always_comb begin
        a = RW'(i_angle);
        if (a >= FULL) begin
            r = a - FULL;
        end else if (a >= 0) begin
            r = a;
        end else if (a >= -FULL) begin
            r = a + FULL;
        end else begin
            r = a + FULL2;
        end
        if (r >= HALF) begin
            r = r - FULL;
        end
        n_neg = 1'b0;
        f = r;
        if (r > QUART) begin
            f = HALF - r;
            n_neg = 1'b1;
        end else if (r < -QUART) begin
            f = -HALF - r;
            n_neg = 1'b1;
        end
        n_z = aapr_pkg::Z_W'(f) <<< 9;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z    <= n_z;
            r_neg  <= n_neg;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_z     = r_z;
    assign o_neg   = r_neg;
    assign o_side  = r_side;

endmodule

### src/aapr_cordic.sv
module aapr_cordic #(
    parameter int CORDIC_STEPS = aapr_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [aapr_pkg::Z_W-1:0]     i_z,
    input  logic                                i_neg,
    input  aapr_pkg::t_side                     i_side,
    output logic                                o_valid,
    output logic signed [aapr_pkg::X_W-1:0]     o_x,
    output logic signed [aapr_pkg::X_W-1:0]     o_y,
    output logic                                o_neg,
    output aapr_pkg::t_side                     o_side
);

    localparam int XW = aapr_pkg::X_W;
    localparam int ZW = aapr_pkg::Z_W;

    logic                 r_valid [CORDIC_STEPS];
    logic signed [XW-1:0] r_x     [CORDIC_STEPS];
    logic signed [XW-1:0] r_y     [CORDIC_STEPS];
    logic signed [ZW-1:0] r_z     [CORDIC_STEPS];
    logic                 r_neg   [CORDIC_STEPS];
    aapr_pkg::t_side      r_side  [CORDIC_STEPS];

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        logic                 vi;
        logic signed [XW-1:0] xi;
        logic signed [XW-1:0] yi;
        logic signed [ZW-1:0] zi;
        logic                 ni;
        aapr_pkg::t_side      si;
        logic signed [XW-1:0] n_x;
        logic signed [XW-1:0] n_y;
        logic signed [ZW-1:0] n_z;

        if (k == 0) begin : g_first
            assign vi = i_valid;
            assign xi = XW'(aapr_pkg::GAIN_Q30);
            assign yi = '0;
            assign zi = i_z;
            assign ni = i_neg;
            assign si = i_side;
        end else begin : g_next
            assign vi = r_valid[k-1];
            assign xi = r_x[k-1];
            assign yi = r_y[k-1];
            assign zi = r_z[k-1];
            assign ni = r_neg[k-1];
            assign si = r_side[k-1];
        end

        always_comb begin
            if (zi >= 0) begin
                n_x = xi - (yi >>> k);
                n_y = yi + (xi >>> k);
                n_z = zi - aapr_pkg::atan_q16(k);
            end else begin
                n_x = xi + (yi >>> k);
                n_y = yi - (xi >>> k);
                n_z = zi + aapr_pkg::atan_q16(k);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= vi;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]    <= n_x;
                r_y[k]    <= n_y;
                r_z[k]    <= n_z;
                r_neg[k]  <= ni;
                r_side[k] <= si;
            end
        end
    end

    assign o_valid = r_valid[CORDIC_STEPS-1];
    assign o_x     = r_x[CORDIC_STEPS-1];
    assign o_y     = r_y[CORDIC_STEPS-1];
    assign o_neg   = r_neg[CORDIC_STEPS-1];
    assign o_side  = r_side[CORDIC_STEPS-1];

endmodule

### src/aapr_matrix.sv
module aapr_matrix (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [aapr_pkg::X_W-1:0]     i_x,
    input  logic signed [aapr_pkg::X_W-1:0]     i_y,
    input  logic                                i_neg,
    input  aapr_pkg::t_side                     i_side,
    output logic                                o_valid,
    output aapr_pkg::t_mat                      o_mat,
    output aapr_pkg::t_point                    o_pt
);

    localparam int XW = aapr_pkg::X_W;
    localparam int OW = XW + 1;
    localparam int UW = 32;
    localparam int PW = UW + OW;
    localparam int SW = 16 + XW;
    localparam int MW = 41;
    localparam int EW = aapr_pkg::E_W;
    localparam logic signed [MW-1:0] ONE = MW'(aapr_pkg::ONE_Q30);

    // stage a: cosine sign, 1 - c, axis products, axis times sine
    logic                 r_va;
    logic signed [XW-1:0] r_ca;
    logic signed [OW-1:0] r_omc;
    logic signed [UW-1:0] r_uu [6];
    logic signed [SW-1:0] r_us [3];
    aapr_pkg::t_point     r_pta;
    logic signed [XW-1:0] n_c;

    // stage b: symmetric products
    logic                 r_vb;
    logic signed [XW-1:0] r_cb;
    logic signed [PW-1:0] r_sym [6];
    logic signed [SW-1:0] r_usb [3];
    aapr_pkg::t_point     r_ptb;

    // stage c: entries
    logic                 r_vc;
    aapr_pkg::t_mat       r_mat;
    aapr_pkg::t_point     r_ptc;

    logic signed [MW-1:0] sy [6];
    logic signed [MW-1:0] sn [3];
    logic signed [MW-1:0] raw [9];
    aapr_pkg::t_mat       n_mat;

    assign n_c = i_neg ? -i_x : i_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ca   <= n_c;
            r_omc  <= OW'(aapr_pkg::ONE_Q30) - OW'(n_c);
            r_uu[0] <= UW'(i_side.ux) * UW'(i_side.ux);
            r_uu[1] <= UW'(i_side.uy) * UW'(i_side.uy);
            r_uu[2] <= UW'(i_side.uz) * UW'(i_side.uz);
            r_uu[3] <= UW'(i_side.ux) * UW'(i_side.uy);
            r_uu[4] <= UW'(i_side.ux) * UW'(i_side.uz);
            r_uu[5] <= UW'(i_side.uy) * UW'(i_side.uz);
            r_us[0] <= SW'(i_side.ux) * SW'(i_y);
            r_us[1] <= SW'(i_side.uy) * SW'(i_y);
            r_us[2] <= SW'(i_side.uz) * SW'(i_y);
            r_pta  <= i_side.pt;

            r_cb <= r_ca;
            for (int j = 0; j < 6; j++) begin
                r_sym[j] <= PW'(r_uu[j]) * PW'(r_omc);
            end
            for (int j = 0; j < 3; j++) begin
                r_usb[j] <= r_us[j];
            end
            r_ptb <= r_pta;

            r_mat <= n_mat;
            r_ptc <= r_ptb;
        end
    end

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            sy[j] = MW'((r_sym[j] + PW'(1 << 27)) >>> 28);
        end
        for (int j = 0; j < 3; j++) begin
            sn[j] = MW'(r_usb[j] >>> 14);
        end
        // xx yy zz xy xz yz ; sine terms ux uy uz
        raw[0] = MW'(r_cb) + sy[0];
        raw[1] = sy[3] - sn[2];
        raw[2] = sy[4] + sn[1];
        raw[3] = sy[3] + sn[2];
        raw[4] = MW'(r_cb) + sy[1];
        raw[5] = sy[5] - sn[0];
        raw[6] = sy[4] - sn[1];
        raw[7] = sy[5] + sn[0];
        raw[8] = MW'(r_cb) + sy[2];
        for (int j = 0; j < 9; j++) begin
            if (raw[j] > ONE) begin
                n_mat[j] = EW'(ONE);
            end else if (raw[j] < -ONE) begin
                n_mat[j] = EW'(-ONE);
            end else begin
                n_mat[j] = EW'(raw[j]);
            end
        end
    end

    assign o_valid = r_vc;
    assign o_mat   = r_mat;
    assign o_pt    = r_ptc;

endmodule

### src/aapr_transform.sv
module aapr_transform (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  aapr_pkg::t_mat         i_mat,
    input  aapr_pkg::t_point       i_pt,
    output logic                   o_valid,
    output aapr_pkg::t_point       o_rot
);

    localparam int PW = 64;
    localparam int AW = 66;
    localparam int RW = AW - 30;
    localparam logic signed [RW-1:0] SMAX = RW'(33'sh0_7FFF_FFFF);
    localparam logic signed [RW-1:0] SMIN = -RW'(33'sh0_8000_0000);

    logic                 r_vd;
    logic signed [PW-1:0] r_prod [9];
    logic signed [31:0]   r_wd;
    logic                 r_ve;
    aapr_pkg::t_point     r_rot;

    logic signed [31:0]   pv [3];
    logic signed [AW-1:0] acc [3];
    logic signed [RW-1:0] sh [3];
    logic signed [31:0]   n_out [3];

    assign pv[0] = i_pt.x;
    assign pv[1] = i_pt.y;
    assign pv[2] = i_pt.z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            acc[a] = AW'(1 << 29) + AW'(r_prod[a*3]) + AW'(r_prod[a*3+1])
                   + AW'(r_prod[a*3+2]);
            sh[a] = acc[a][AW-1:30];
            if (sh[a] > SMAX) begin
                n_out[a] = 32'(SMAX);
            end else if (sh[a] < SMIN) begin
                n_out[a] = 32'(SMIN);
            end else begin
                n_out[a] = 32'(sh[a]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else if (i_en) begin
            r_vd <= i_valid;
            r_ve <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 9; j++) begin
                r_prod[j] <= PW'(i_mat[j]) * PW'(pv[j % 3]);
            end
            r_wd    <= i_pt.w;
            r_rot.x <= n_out[0];
            r_rot.y <= n_out[1];
            r_rot.z <= n_out[2];
            r_rot.w <= r_wd;
        end
    end

    assign o_valid = r_ve;
    assign o_rot   = r_rot;

endmodule

### src/axis_angle_point_rotator_unit.sv
// channel   dir  handshake           payload
// request   in   i_valid / o_ready   i_point_x/y/z/w, i_axis_x/y/z, i_angle_deg
// result    out  o_valid / i_ready   o_rot_x/y/z/w
//
// one request per cycle while no result is held, pipeline stages:
// angle fold 1, one cordic step per stage, matrix 3, transform and output 2
// synchronous active-low reset clears every valid bit, payload is not reset
// a held result stalls the whole pipeline; o_ready is low only then
`include "axis_angle_point_rotator_unit_assert.svh"

module axis_angle_point_rotator_unit #(
    parameter int CORDIC_STEPS = aapr_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic signed [31:0] i_point_w,
    input  logic signed [15:0] i_axis_x,
    input  logic signed [15:0] i_axis_y,
    input  logic signed [15:0] i_axis_z,
    input  logic signed [16:0] i_angle_deg,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_rot_x,
    output logic signed [31:0] o_rot_y,
    output logic signed [31:0] o_rot_z,
    output logic signed [31:0] o_rot_w
);

    logic                                en;
    aapr_pkg::t_side                     side_in;
    logic                                f_valid;
    logic signed [aapr_pkg::Z_W-1:0]     f_z;
    logic                                f_neg;
    aapr_pkg::t_side                     f_side;
    logic                                c_valid;
    logic signed [aapr_pkg::X_W-1:0]     c_x;
    logic signed [aapr_pkg::X_W-1:0]     c_y;
    logic                                c_neg;
    aapr_pkg::t_side                     c_side;
    logic                                m_valid;
    aapr_pkg::t_mat                      m_mat;
    aapr_pkg::t_point                    m_pt;
    aapr_pkg::t_point                    rot;
    logic                                ent_ok;

    assign en = !o_valid || i_ready;
    assign o_ready = en;

    assign side_in.pt.x = i_point_x;
    assign side_in.pt.y = i_point_y;
    assign side_in.pt.z = i_point_z;
    assign side_in.pt.w = i_point_w;
    assign side_in.ux   = i_axis_x;
    assign side_in.uy   = i_axis_y;
    assign side_in.uz   = i_axis_z;

    aapr_angle_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_angle (i_angle_deg),
        .i_side  (side_in),
        .o_valid (f_valid),
        .o_z     (f_z),
        .o_neg   (f_neg),
        .o_side  (f_side)
    );

    aapr_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_z     (f_z),
        .i_neg   (f_neg),
        .i_side  (f_side),
        .o_valid (c_valid),
        .o_x     (c_x),
        .o_y     (c_y),
        .o_neg   (c_neg),
        .o_side  (c_side)
    );

    aapr_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (c_valid),
        .i_x     (c_x),
        .i_y     (c_y),
        .i_neg   (c_neg),
        .i_side  (c_side),
        .o_valid (m_valid),
        .o_mat   (m_mat),
        .o_pt    (m_pt)
    );

    aapr_transform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (m_valid),
        .i_mat   (m_mat),
        .i_pt    (m_pt),
        .o_valid (o_valid),
        .o_rot   (rot)
    );

    assign o_rot_x = rot.x;
    assign o_rot_y = rot.y;
    assign o_rot_z = rot.z;
    assign o_rot_w = rot.w;

    always_comb begin
        ent_ok = 1'b1;
        for (int j = 0; j < 9; j++) begin
            if (m_mat[j] > aapr_pkg::E_W'(aapr_pkg::ONE_Q30)
                || m_mat[j] < -aapr_pkg::E_W'(aapr_pkg::ONE_Q30)) begin
                ent_ok = 1'b0;
            end
        end
    end

    `AAPR_ASSERT_IMP(a_entry_range, m_valid, ent_ok)
    `AAPR_ASSERT_NEXT(a_stall_freeze, !en, $stable(c_valid) && $stable(m_valid))
    `AAPR_ASSERT_NEXT_RST(a_reset_clear, !i_rst_n, !o_valid && !m_valid && !c_valid)

endmodule
